FILE: hw/rtl/lgfg_pkg.sv
// Shared constants, codes and controller/datapath interface structs for the
// LED gradient frame generator. No dependencies.
package lgfg_pkg;

	localparam int MAX_ZONES  = 64;
	localparam int ZONE_W     = $clog2(MAX_ZONES);
	localparam int ZCNT_W     = ZONE_W + 1;
	localparam int TICK_W     = 32;
	localparam int FRAME_W    = 16;
	localparam int NUM_CH     = 3;
	localparam int CH_W       = 8;
	localparam int COLOR_W    = NUM_CH * CH_W;
	// den = 2 * df * dz, with df < 2^FRAME_W and dz < MAX_ZONES.
	localparam int NUM_W      = FRAME_W + ZONE_W;
	localparam int DEN_W      = NUM_W + 1;
	// Dividends stay below 2^CH_W * den.
	localparam int N_W        = DEN_W + CH_W;
	localparam int DSH_W      = DEN_W + CH_W - 1;
	localparam int MOD_STEPS  = TICK_W;
	localparam int DIV_STEPS  = CH_W;
	localparam int CNT_W      = $clog2(MOD_STEPS);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COLOR_W;

	localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = CFG_IDX_W'(4);

	typedef struct packed {
		logic load;
		logic mod_step;
		logic mul1;
		logic mul2;
		logic div_step;
		logic fix;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic loop;
		logic last;
	} status_t;

endpackage

FILE: hw/rtl/lgfg_ctrl.sv
// Sequencing state machine of the LED gradient frame generator.
// Depends on lgfg_pkg for the command and status structs.
module lgfg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  lgfg_pkg::status_t status,
	output lgfg_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIX  = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0]                 state_q;
	logic [2:0]                 state_d;
	logic [lgfg_pkg::CNT_W-1:0] cnt_q;
	logic                       mod_done;
	logic                       div_done;

	assign mod_done  = (cnt_q == lgfg_pkg::CNT_W'(lgfg_pkg::MOD_STEPS - 1));
	assign div_done  = (cnt_q == lgfg_pkg::CNT_W'(lgfg_pkg::DIV_STEPS - 1));
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);

	always_comb begin
		cmd.load     = in_valid && in_ready;
		cmd.mod_step = (state_q == ST_MOD);
		cmd.mul1     = (state_q == ST_MUL1);
		cmd.mul2     = (state_q == ST_MUL2);
		cmd.div_step = (state_q == ST_DIV);
		cmd.fix      = (state_q == ST_FIX);
		cmd.advance  = out_valid && out_ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (status.empty) begin
						state_d = ST_EMIT;
					end else if (status.loop) begin
						state_d = ST_MOD;
					end else begin
						state_d = ST_MUL1;
					end
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_ready && status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_MOD && !mod_done) || (state_q == ST_DIV && !div_done)) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("lgfg_ctrl: second transfer accepted while a tick is in progress");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_done) |=> (state_q == ST_FIX))
		else $error("lgfg_ctrl: division sequence did not finish on time");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && status.last) |=> in_ready)
		else $error("lgfg_ctrl: final result did not return the block to idle");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (!out_valid && !in_ready))
		else $error("lgfg_ctrl: handshake open during division");

endmodule

FILE: hw/rtl/lgfg_dpath.sv
// Datapath of the LED gradient frame generator: configuration registers,
// tick modulo, setup multiplies, per-channel dividers and the zone stepper. Uses lgfg_pkg.
module lgfg_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [lgfg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lgfg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [lgfg_pkg::TICK_W-1:0]      tick_index,
	input  lgfg_pkg::cmd_t                   cmd,
	output lgfg_pkg::status_t                status,
	output logic [lgfg_pkg::ZONE_W-1:0]      zone_index,
	output logic [lgfg_pkg::CH_W-1:0]        red,
	output logic [lgfg_pkg::CH_W-1:0]        green,
	output logic [lgfg_pkg::CH_W-1:0]        blue,
	output logic                             last,
	output logic                             no_frame
);

	localparam int NC  = lgfg_pkg::NUM_CH;
	localparam int CW  = lgfg_pkg::CH_W;
	localparam int DW  = lgfg_pkg::DEN_W;
	localparam int NW  = lgfg_pkg::N_W;
	localparam int FW  = lgfg_pkg::FRAME_W;
	localparam int ZW  = lgfg_pkg::ZONE_W;
	localparam int ZCW = lgfg_pkg::ZCNT_W;
	localparam int TW  = lgfg_pkg::TICK_W;

	// Configuration registers.
	logic [lgfg_pkg::COLOR_W-1:0] start_q;
	logic [lgfg_pkg::COLOR_W-1:0] end_q;
	logic [ZCW-1:0]               zcnt_q;
	logic [FW-1:0]                fcnt_q;
	logic                         loop_q;

	// Per-tick setup.
	logic [ZCW-1:0]               zs_q;
	logic [FW-1:0]                df_q;
	logic [ZW-1:0]                dz_q;
	logic [TW-1:0]                div_q;
	logic [FW:0]                  rem_q;
	logic [DW-1:0]                den_q;
	logic [lgfg_pkg::NUM_W-1:0]   num0_q;
	logic [lgfg_pkg::DSH_W-1:0]   dsh_q;
	logic                         no_frame_q;
	logic [ZW-1:0]                zone_q;

	// Per-channel lanes.
	logic [NW-1:0] nrem_q [NC];
	logic [CW-1:0] nquo_q [NC];
	logic [NW-1:0] srem_q [NC];
	logic [CW-1:0] squo_q [NC];
	logic          neg_q  [NC];
	logic [CW-1:0] acc_q  [NC];
	logic [DW-1:0] accr_q [NC];
	logic [CW-1:0] stq_q  [NC];
	logic [DW-1:0] str_q  [NC];

	logic [ZCW-1:0] zs_d;
	logic [TW-1:0]  fmax;
	logic [FW:0]    rsh;
	logic [DW-1:0]  num_ext;
	logic [CW-1:0]  ch_a [NC];
	logic [CW-1:0]  ch_b [NC];
	logic [CW-1:0]  ch_diff [NC];

	always_comb begin
		zs_d    = (zcnt_q > ZCW'(lgfg_pkg::MAX_ZONES)) ? ZCW'(lgfg_pkg::MAX_ZONES) : zcnt_q;
		fmax    = TW'(fcnt_q - 1'b1);
		rsh     = {rem_q[FW-1:0], div_q[TW-1]};
		num_ext = DW'(num0_q);
		for (int c = 0; c < NC; c++) begin
			ch_a[c]    = start_q[CW*(NC-1-c) +: CW];
			ch_b[c]    = end_q[CW*(NC-1-c) +: CW];
			ch_diff[c] = (ch_b[c] >= ch_a[c]) ? (ch_b[c] - ch_a[c]) : (ch_a[c] - ch_b[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '1;
			zcnt_q  <= ZCW'(8);
			fcnt_q  <= FW'(16);
			loop_q  <= 1'b1;
		end else if (cfg_write_en) begin
			case (cfg_index)
				lgfg_pkg::REG_START_COLOR: start_q <= cfg_data;
				lgfg_pkg::REG_END_COLOR:   end_q   <= cfg_data;
				lgfg_pkg::REG_ZONE_COUNT:  zcnt_q  <= cfg_data[ZCW-1:0];
				lgfg_pkg::REG_FRAME_COUNT: fcnt_q  <= cfg_data[FW-1:0];
				lgfg_pkg::REG_LOOP_MODE:   loop_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zs_q       <= zs_d;
			dz_q       <= (zs_d > ZCW'(1)) ? ZW'(zs_d - 1'b1) : ZW'(1);
			df_q       <= (fcnt_q > FW'(1)) ? (fcnt_q - 1'b1) : FW'(1);
			div_q      <= tick_index;
			if (loop_q) begin
				rem_q <= '0;
			end else begin
				rem_q <= (tick_index < fmax) ? {1'b0, tick_index[FW-1:0]} : {1'b0, fmax[FW-1:0]};
			end
			no_frame_q <= (zcnt_q == '0) || (fcnt_q == '0);
			zone_q     <= '0;
			for (int c = 0; c < NC; c++) begin
				acc_q[c] <= '0;
			end
		end

		// Restoring modulo, one tick bit a cycle.
		if (cmd.mod_step) begin
			div_q <= {div_q[TW-2:0], 1'b0};
			if (rsh >= {1'b0, fcnt_q}) begin
				rem_q <= rsh - {1'b0, fcnt_q};
			end else begin
				rem_q <= rsh;
			end
		end

		if (cmd.mul1) begin
			den_q  <= {(DW-1)'(df_q) * (DW-1)'(dz_q), 1'b0};
			num0_q <= lgfg_pkg::NUM_W'(rem_q[FW-1:0]) * lgfg_pkg::NUM_W'(dz_q);
			for (int c = 0; c < NC; c++) begin
				srem_q[c] <= NW'(ch_diff[c]) * NW'(df_q);
				neg_q[c]  <= (ch_b[c] < ch_a[c]);
			end
		end

		if (cmd.mul2) begin
			dsh_q <= {den_q, {(CW-1){1'b0}}};
			for (int c = 0; c < NC; c++) begin
				nrem_q[c] <= NW'(ch_a[c]) * NW'(den_q - num_ext) + NW'(ch_b[c]) * NW'(num_ext);
			end
		end

		// Eight-bit quotient restoring division of both dividends of each lane.
		if (cmd.div_step) begin
			dsh_q <= dsh_q >> 1;
			for (int c = 0; c < NC; c++) begin
				if (nrem_q[c] >= NW'(dsh_q)) begin
					nrem_q[c] <= nrem_q[c] - NW'(dsh_q);
					nquo_q[c] <= {nquo_q[c][CW-2:0], 1'b1};
				end else begin
					nquo_q[c] <= {nquo_q[c][CW-2:0], 1'b0};
				end
				if (srem_q[c] >= NW'(dsh_q)) begin
					srem_q[c] <= srem_q[c] - NW'(dsh_q);
					squo_q[c] <= {squo_q[c][CW-2:0], 1'b1};
				end else begin
					squo_q[c] <= {squo_q[c][CW-2:0], 1'b0};
				end
			end
		end

		// Turn the unsigned step into a floored signed quotient and remainder.
		if (cmd.fix) begin
			for (int c = 0; c < NC; c++) begin
				acc_q[c]  <= nquo_q[c];
				accr_q[c] <= nrem_q[c][DW-1:0];
				if (!neg_q[c]) begin
					stq_q[c] <= squo_q[c];
					str_q[c] <= srem_q[c][DW-1:0];
				end else if (srem_q[c] != '0) begin
					stq_q[c] <= ~squo_q[c];
					str_q[c] <= den_q - srem_q[c][DW-1:0];
				end else begin
					stq_q[c] <= CW'(0) - squo_q[c];
					str_q[c] <= '0;
				end
			end
		end

		if (cmd.advance) begin
			zone_q <= zone_q + 1'b1;
			for (int c = 0; c < NC; c++) begin
				if (({1'b0, accr_q[c]} + {1'b0, str_q[c]}) >= {1'b0, den_q}) begin
					accr_q[c] <= DW'({1'b0, accr_q[c]} + {1'b0, str_q[c]} - {1'b0, den_q});
					acc_q[c]  <= acc_q[c] + stq_q[c] + CW'(1);
				end else begin
					accr_q[c] <= accr_q[c] + str_q[c];
					acc_q[c]  <= acc_q[c] + stq_q[c];
				end
			end
		end
	end

	always_comb begin
		status.empty = (zcnt_q == '0) || (fcnt_q == '0);
		status.loop  = loop_q;
		status.last  = no_frame_q || ({1'b0, zone_q} == (zs_q - 1'b1));
	end

	assign zone_index = zone_q;
	assign red        = acc_q[0];
	assign green      = acc_q[1];
	assign blue       = acc_q[2];
	assign last       = status.last;
	assign no_frame   = no_frame_q;

endmodule

FILE: hw/rtl/led_gradient_frame_generator_unit.sv
// Top level of the LED gradient frame generator: controller and datapath.
// Depends on lgfg_pkg, lgfg_ctrl and lgfg_dpath.

// Each accepted tick_index transfer produces one colour per zone, zone 0 first,
// with last set on the final one; if the zone or frame count is zero a single
// result with no_frame and last set, and all other fields zero, is given instead.
// The frame is tick_index modulo frame_count in loop mode and tick_index clamped
// to the last frame otherwise. Zone counts above 64 are treated as 64. Each
// channel is from + (to - from) * w rounded down, where w is the exact mean of
// frame/(frames-1) and zone/(zones-1), each denominator at least one.
// Timing: the block handles one tick at a time. After the input transfer it
// runs the bit-serial modulo (skipped with loop mode off), the setup
// multiplies, the division for all three channels in parallel and a
// correction step, and then offers the first result. Results then follow one
// per cycle while out_ready is high. The input is ready again in the cycle
// after the last result transfer. Configuration is written through
// cfg_write_en, cfg_index and cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce; indices beyond
// loop_mode are ignored.

module led_gradient_frame_generator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [lgfg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lgfg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [lgfg_pkg::TICK_W-1:0]      tick_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [lgfg_pkg::ZONE_W-1:0]      zone_index,
	output logic [lgfg_pkg::CH_W-1:0]        red,
	output logic [lgfg_pkg::CH_W-1:0]        green,
	output logic [lgfg_pkg::CH_W-1:0]        blue,
	output logic                             last,
	output logic                             no_frame
);

	// Commands flow from the controller to the datapath, status flows back.
	lgfg_pkg::cmd_t    cmd;
	lgfg_pkg::status_t status;

	// The controller owns both handshakes; the results are held in the
	// datapath registers for as long as out_valid waits for out_ready.
	lgfg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath steps each channel from zone to zone with one add and
	// one compare-and-subtract, so no division is needed once set up.
	lgfg_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tick_index   (tick_index),
		.cmd          (cmd),
		.status       (status),
		.zone_index   (zone_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.last         (last),
		.no_frame     (no_frame)
	);

endmodule
